// ===== sv/lts_pkg.sv =====
// Shared types, codes and constant tables for the triangle row search block.
`timescale 1ns / 1ps

package lts_pkg;

    // Request codes.
    localparam logic REQ_BUILD  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_BUILT = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_NUM_ROWS    = 1'b0;
    localparam logic CFG_SEARCH_MODE = 1'b1;

    // Search mode codes.
    localparam logic MODE_BINARY = 1'b0;

    // Datapath operation codes.
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_ACCEPT    = 4'd1;
    localparam logic [3:0] OP_BLD_RD    = 4'd2;
    localparam logic [3:0] OP_BLD_WR    = 4'd3;
    localparam logic [3:0] OP_BIN_RD    = 4'd4;
    localparam logic [3:0] OP_PROBE_CMP = 4'd5;
    localparam logic [3:0] OP_RD_HI     = 4'd6;
    localparam logic [3:0] OP_RD_LO     = 4'd7;
    localparam logic [3:0] OP_INT_CHK   = 4'd8;
    localparam logic [3:0] OP_DIV       = 4'd9;
    localparam logic [3:0] OP_RD_PROBE  = 4'd10;
    localparam logic [3:0] OP_RESULT    = 4'd11;

    // The interpolation quotient never exceeds the span width, so five bits suffice.
    localparam logic [2:0] DIV_TOP_BIT = 3'd4;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic [3:0] op;
        logic [1:0] res_status;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_zero;
        logic row_ok;
        logic mode;
        logic lohi_ok;
        logic eq;
        logic int_in;
        logic int_flat;
        logic div_last;
        logic bld_last;
    } dp_stat_t;

    // Binomial table indexed by {n[3:0], k[3:0]}.
    typedef logic [15:0] binom_tab_t [0:255];

    function automatic binom_tab_t binom_build();
        binom_tab_t t;
        for (int n = 0; n < 16; n++)
        begin
            for (int k = 0; k < 16; k++)
            begin
                if (k == 0)
                    t[n * 16 + k] = 16'd1;
                else if (n == 0)
                    t[n * 16 + k] = 16'd0;
                else
                    t[n * 16 + k] = t[(n - 1) * 16 + k - 1] + t[(n - 1) * 16 + k];
            end
        end
        return t;
    endfunction

    localparam binom_tab_t BINOM_TAB = binom_build();

endpackage

// ===== sv/lts_ctrl.sv =====
// Controller state machine that sequences builds and searches.
`timescale 1ns / 1ps

module lts_ctrl
    import lts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     req_type,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_BRD  = 4'd1;
    localparam logic [3:0] S_BWR  = 4'd2;
    localparam logic [3:0] S_SCHK = 4'd3;
    localparam logic [3:0] S_BTOP = 4'd4;
    localparam logic [3:0] S_BCMP = 4'd5;
    localparam logic [3:0] S_ITOP = 4'd6;
    localparam logic [3:0] S_IRHI = 4'd7;
    localparam logic [3:0] S_IRLO = 4'd8;
    localparam logic [3:0] S_IDIV = 4'd9;
    localparam logic [3:0] S_IRDM = 4'd10;
    localparam logic [3:0] S_ICMP = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [1:0] res_reg, res_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state, pending status and datapath command.
    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        cmd.res_status = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_ACCEPT;
                    if (req_type == REQ_BUILD)
                    begin
                        if (stat.n_zero)
                        begin
                            res_next   = ST_BUILT;
                            state_next = S_DONE;
                        end
                        else
                            state_next = S_BRD;
                    end
                    else
                        state_next = S_SCHK;
                end
            end
            S_BRD:
            begin
                cmd.op     = OP_BLD_RD;
                state_next = S_BWR;
            end
            S_BWR:
            begin
                cmd.op = OP_BLD_WR;
                if (stat.bld_last)
                begin
                    res_next   = ST_BUILT;
                    state_next = S_DONE;
                end
                else
                    state_next = S_BRD;
            end
            S_SCHK:
            begin
                if (!stat.row_ok)
                begin
                    res_next   = ST_RANGE;
                    state_next = S_DONE;
                end
                else if (stat.mode == MODE_BINARY)
                    state_next = S_BTOP;
                else
                    state_next = S_ITOP;
            end
            S_BTOP:
            begin
                if (!stat.lohi_ok)
                begin
                    res_next   = ST_MISS;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_BIN_RD;
                    state_next = S_BCMP;
                end
            end
            S_BCMP:
            begin
                cmd.op = OP_PROBE_CMP;
                if (stat.eq)
                begin
                    res_next   = ST_FOUND;
                    state_next = S_DONE;
                end
                else
                    state_next = S_BTOP;
            end
            S_ITOP:
            begin
                if (!stat.lohi_ok)
                begin
                    res_next   = ST_MISS;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_RD_HI;
                    state_next = S_IRHI;
                end
            end
            S_IRHI:
            begin
                cmd.op     = OP_RD_LO;
                state_next = S_IRLO;
            end
            S_IRLO:
            begin
                cmd.op = OP_INT_CHK;
                if (!stat.int_in)
                begin
                    res_next   = ST_MISS;
                    state_next = S_DONE;
                end
                else if (stat.int_flat)
                begin
                    res_next   = stat.eq ? ST_FOUND : ST_MISS;
                    state_next = S_DONE;
                end
                else
                    state_next = S_IDIV;
            end
            S_IDIV:
            begin
                cmd.op = OP_DIV;
                if (stat.div_last)
                    state_next = S_IRDM;
            end
            S_IRDM:
            begin
                cmd.op     = OP_RD_PROBE;
                state_next = S_ICMP;
            end
            S_ICMP:
            begin
                cmd.op = OP_PROBE_CMP;
                if (stat.eq)
                begin
                    res_next   = ST_FOUND;
                    state_next = S_DONE;
                end
                else
                    state_next = S_ITOP;
            end
            S_DONE:
            begin
                // Load the result once the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_reg       <= ST_FOUND;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/lts_dp.sv =====
// Datapath: triangle memory, configuration, search registers and the quotient unit.
`timescale 1ns / 1ps

module lts_dp
    import lts_pkg::*;
#(
    parameter int ROWS_MAX = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic               cfg_valid,
    input  logic               cfg_index,
    input  logic        [5:0]  cfg_data,
    input  logic               req_type,
    input  logic        [4:0]  row,
    input  logic signed [31:0] key,
    output logic        [1:0]  status,
    output logic        [4:0]  index,
    output logic        [4:0]  steps
);

    localparam int DEPTH = ROWS_MAX * (ROWS_MAX + 1) / 2;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [5:0] ROWS_LIM = 6'(ROWS_MAX);

    // Triangle memory.
    logic [31:0]   mem [0:DEPTH-1];
    logic [31:0]   rdata_reg;
    logic [AW-1:0] raddr, waddr;
    logic          re, we;
    logic [31:0]   wdata;

    // Configuration and build registers.
    logic [5:0]    num_rows_reg;
    logic          mode_reg;
    logic [5:0]    built_reg, n_reg;
    logic [4:0]    i_reg, j_reg;
    logic [AW-1:0] base_reg, pbase_reg;
    logic [31:0]   left_reg;

    // Search registers.
    logic [4:0]         row_reg;
    logic signed [31:0] key_reg;
    logic [AW-1:0]      sbase_reg;
    logic signed [6:0]  lo_reg, hi_reg;
    logic [4:0]         mid_reg, found_reg, steps_reg;
    logic signed [31:0] vhi_reg;
    logic [37:0]        num_reg;
    logic [32:0]        den_reg;
    logic [4:0]         q_reg;
    logic [2:0]         dcnt_reg;

    // Result registers.
    logic [1:0] res_status_reg;
    logic [4:0] res_index_reg, res_steps_reg;

    logic [5:0]         n_sat;
    logic signed [31:0] rdata_s;
    logic signed [6:0]  span, bin_mid7;
    logic [4:0]         bin_mid, int_mid;
    logic [10:0]        rb_full;
    logic signed [32:0] kd, dd;
    logic [37:0]        prod, den_sh;
    logic               edge_ent, odd_rule;
    logic [3:0]         bn, bk;
    logic [15:0]        binom;
    logic [31:0]        inner;

    assign n_sat    = (num_rows_reg > ROWS_LIM) ? ROWS_LIM : num_rows_reg;
    assign rdata_s  = signed'(rdata_reg);
    assign span     = hi_reg - lo_reg;
    assign bin_mid7 = lo_reg + (span >>> 1);
    assign bin_mid  = bin_mid7[4:0];
    assign int_mid  = lo_reg[4:0] + q_reg;
    assign rb_full  = (11'(row) * (11'(row) + 11'd1)) >> 1;

    // Interpolation numerator and denominator, both non-negative when used.
    assign kd     = {key_reg[31], key_reg} - {rdata_s[31], rdata_s};
    assign dd     = {vhi_reg[31], vhi_reg} - {rdata_s[31], rdata_s};
    assign prod   = {33'd0, span[4:0]} * {5'd0, kd};
    assign den_sh = {5'd0, den_reg} << dcnt_reg;

    // Inner entry: sum of the two above, less a binomial on even rows at odd columns.
    assign edge_ent = (j_reg == 5'd0) || (j_reg == i_reg);
    assign odd_rule = !i_reg[0] && j_reg[0];
    assign bn       = 4'((i_reg >> 1) - 5'd1);
    assign bk       = 4'((j_reg - 5'd1) >> 1);
    assign binom    = BINOM_TAB[{bn, bk}];
    assign inner    = left_reg + rdata_reg - (odd_rule ? 32'(binom) : 32'd0);

    // Status flags for the controller.
    always_comb
    begin
        stat.n_zero   = (n_sat == 6'd0);
        stat.row_ok   = ({1'b0, row_reg} < built_reg);
        stat.mode     = mode_reg;
        stat.lohi_ok  = (lo_reg <= hi_reg);
        stat.eq       = (rdata_s == key_reg);
        stat.int_in   = (key_reg <= vhi_reg) && (key_reg >= rdata_s);
        stat.int_flat = (lo_reg == hi_reg) || (rdata_s == vhi_reg);
        stat.div_last = (dcnt_reg == 3'd0);
        stat.bld_last = (j_reg == i_reg) && ({1'b0, i_reg} == n_reg - 6'd1);
    end

    // Memory address and enable selection.
    always_comb
    begin
        re    = 1'b1;
        raddr = sbase_reg + AW'(lo_reg[4:0]);
        case (cmd.op)
            OP_BLD_RD:   raddr = pbase_reg + AW'(j_reg);
            OP_BIN_RD:   raddr = sbase_reg + AW'(bin_mid);
            OP_RD_HI:    raddr = sbase_reg + AW'(hi_reg[4:0]);
            OP_RD_LO:    raddr = sbase_reg + AW'(lo_reg[4:0]);
            OP_RD_PROBE: raddr = sbase_reg + AW'(int_mid);
            default:     re    = 1'b0;
        endcase
        we    = (cmd.op == OP_BLD_WR);
        waddr = base_reg + AW'(j_reg);
        wdata = edge_ent ? 32'd1 : inner;
    end

    // Memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    // Configuration and stored row count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= 6'd32;
            mode_reg     <= MODE_BINARY;
            built_reg    <= 6'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_NUM_ROWS:    num_rows_reg <= cfg_data;
                    CFG_SEARCH_MODE: mode_reg     <= cfg_data[0];
                    default:         num_rows_reg <= num_rows_reg;
                endcase
            end
            if (cmd.op == OP_ACCEPT && req_type == REQ_BUILD)
                built_reg <= n_sat;
        end
    end

    // Build and search working registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                n_reg     <= n_sat;
                i_reg     <= 5'd0;
                j_reg     <= 5'd0;
                base_reg  <= '0;
                pbase_reg <= '0;
                row_reg   <= row;
                key_reg   <= key;
                sbase_reg <= rb_full[AW-1:0];
                lo_reg    <= 7'sd0;
                hi_reg    <= signed'(7'((6'(row) + 6'd1) >> 1));
                steps_reg <= 5'd0;
                found_reg <= 5'd0;
            end
            OP_BLD_WR:
            begin
                left_reg <= rdata_reg;
                if (j_reg == i_reg)
                begin
                    i_reg     <= i_reg + 5'd1;
                    j_reg     <= 5'd0;
                    pbase_reg <= base_reg;
                    base_reg  <= base_reg + AW'(i_reg) + AW'(1);
                end
                else
                    j_reg <= j_reg + 5'd1;
            end
            OP_BIN_RD:
            begin
                mid_reg   <= bin_mid;
                steps_reg <= steps_reg + 5'd1;
            end
            OP_PROBE_CMP:
            begin
                found_reg <= mid_reg;
                if (rdata_s < key_reg)
                    lo_reg <= signed'({2'b00, mid_reg}) + 7'sd1;
                else
                    hi_reg <= signed'({2'b00, mid_reg}) - 7'sd1;
            end
            OP_RD_LO:
            begin
                vhi_reg <= rdata_s;
            end
            OP_INT_CHK:
            begin
                found_reg <= lo_reg[4:0];
                if (stat.int_in)
                    steps_reg <= steps_reg + 5'd1;
                num_reg  <= prod;
                den_reg  <= dd;
                q_reg    <= 5'd0;
                dcnt_reg <= DIV_TOP_BIT;
            end
            OP_DIV:
            begin
                // One quotient bit per cycle, restoring.
                if (num_reg >= den_sh)
                begin
                    num_reg         <= num_reg - den_sh;
                    q_reg[dcnt_reg] <= 1'b1;
                end
                dcnt_reg <= dcnt_reg - 3'd1;
            end
            OP_RD_PROBE:
            begin
                mid_reg <= int_mid;
            end
            default:
            begin
                left_reg <= left_reg;
            end
        endcase
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_RESULT)
        begin
            res_status_reg <= cmd.res_status;
            res_index_reg  <= (cmd.res_status == ST_FOUND) ? found_reg : 5'd0;
            res_steps_reg  <= steps_reg;
        end
    end

    assign status = res_status_reg;
    assign index  = res_index_reg;
    assign steps  = res_steps_reg;

endmodule

// ===== sv/lozanic_triangle_row_search.sv =====
// Top level of the triangle row search block.
`timescale 1ns / 1ps

// A build transaction fills the on-chip memory with the first num_rows rows of the
// Lozanic triangle, reading the entry above and then writing each entry. A search
// transaction looks for key in the non-decreasing first half of a built row: binary
// search reads and compares one probe per step, and interpolation search makes three
// memory reads per probe and runs the quotient unit. One transaction is worked on at
// a time; a new one is taken while the previous result waits in the output register.
// Configuration is always ready and should be written only while the block is idle.
module lozanic_triangle_row_search
    import lts_pkg::*;
#(
    parameter int ROWS_MAX = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic        [5:0]  cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic        [4:0]  row,
    input  logic signed [31:0] key,
    output logic               out_valid,
    input  logic               out_ready,
    output logic        [1:0]  status,
    output logic        [4:0]  index,
    output logic        [4:0]  steps
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    // Sequencer.
    lts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Memory and arithmetic.
    lts_dp #(
        .ROWS_MAX (ROWS_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_type  (req_type),
        .row       (row),
        .key       (key),
        .status    (status),
        .index     (index),
        .steps     (steps)
    );

endmodule
